>>> rtl/cgme_pkg.sv
// cgme_pkg: types, codes and fixed widths shared by the controlled gate matrix expand unit
// no dependencies; imported by every module under rtl

package cgme_pkg;

  localparam int ROW_W     = 8;
  localparam int ROW_SEL_W = 3;
  localparam int SRC_W     = 4;
  localparam int TGT_LIM   = 6;
  localparam int SLOT_W    = 6;
  localparam int QIDX_W    = 6;
  localparam int RANK_W    = 7;
  localparam int CFG_W     = 64;
  localparam int TLIST_W   = 24;
  localparam int TCNT_W    = 3;
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = 6;
  localparam int DATA_W    = 64;

  localparam logic [DATA_W-1:0] ONE_BITS = 64'h3FF0_0000_0000_0000;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_OPERAND_MASK  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_LIST   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_COUNT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CONTROL_MASK  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CONTROL_VALUE = 3'd4;

  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_ONE   = 2'd1,
    KIND_ENTRY = 2'd2,
    KIND_RANGE = 2'd3
  } kind_t;

  // qubit ranks folded onto the row/column bits
  typedef struct packed {
    logic [ROW_W-1:0]                rmask;
    logic [ROW_W-1:0]                cmask;
    logic [ROW_W-1:0]                cval;
    logic                            cfail;
    logic [ROW_W-1:0]                tmask;
    logic [TGT_LIM-1:0][ROW_W-1:0]   tsel;
  } cgme_map_t;

endpackage

>>> rtl/cgme_cfg.sv
// cgme_cfg: register file on the apb-style port and the rank sweep that folds it into a bit map
// depends on cgme_pkg

module cgme_cfg import cgme_pkg::*; #(
  parameter int MAX_QUBITS  = 8,
  parameter int MAX_TARGETS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [CFG_W-1:0]     pwdata,
  output logic [CFG_W-1:0]     prdata,
  output logic                 pready,
  output logic                 busy,
  output cgme_map_t            map
);

  logic [CFG_W-1:0]   operand_mask_r;
  logic [TLIST_W-1:0] target_list_r;
  logic [TCNT_W-1:0]  target_count_r;
  logic [CFG_W-1:0]   control_mask_r;
  logic [CFG_W-1:0]   control_value_r;

  logic                      wr;
  logic [REG_IDX_W-1:0]      idx;
  logic                      busy_r;
  logic [QIDX_W-1:0]         q_r;
  logic [RANK_W-1:0]         rank_r;
  logic [RANK_W-1:0]         rank_nxt;
  cgme_map_t                 map_r;
  cgme_map_t                 map_nxt;
  logic [TCNT_W-1:0]         k;
  logic [TGT_LIM*SLOT_W-1:0] slots;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
  assign busy   = busy_r || wr;
  assign map    = map_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operand_mask_r  <= '0;
      target_list_r   <= '0;
      target_count_r  <= '0;
      control_mask_r  <= '0;
      control_value_r <= '0;
    end else if (wr) begin
      case (idx)
        REG_OPERAND_MASK:  operand_mask_r  <= pwdata;
        REG_TARGET_LIST:   target_list_r   <= pwdata[TLIST_W-1:0];
        REG_TARGET_COUNT:  target_count_r  <= pwdata[TCNT_W-1:0];
        REG_CONTROL_MASK:  control_mask_r  <= pwdata;
        REG_CONTROL_VALUE: control_value_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OPERAND_MASK:  prdata = operand_mask_r;
      REG_TARGET_LIST:   prdata = CFG_W'(target_list_r);
      REG_TARGET_COUNT:  prdata = CFG_W'(target_count_r);
      REG_CONTROL_MASK:  prdata = control_mask_r;
      REG_CONTROL_VALUE: prdata = control_value_r;
      default:           prdata = '0;
    endcase
  end

  assign k     = (target_count_r > TCNT_W'(MAX_TARGETS)) ? TCNT_W'(MAX_TARGETS) : target_count_r;
  assign slots = (TGT_LIM*SLOT_W)'(target_list_r);

  // one global qubit per cycle, rank_r counts operand bits below q_r
  always_comb begin
    logic                 rank_lo;
    logic [ROW_SEL_W-1:0] pos;
    rank_lo  = rank_r < RANK_W'(ROW_W);
    pos      = rank_r[ROW_SEL_W-1:0];
    map_nxt  = map_r;
    rank_nxt = rank_r;
    if (control_mask_r[q_r]) begin
      if (rank_lo) begin
        map_nxt.cmask[pos] = 1'b1;
        if (control_value_r[q_r]) map_nxt.cval[pos] = 1'b1;
      end else if (control_value_r[q_r]) begin
        map_nxt.cfail = 1'b1;
      end
    end
    for (int j = 0; j < MAX_TARGETS; j++) begin
      if (TCNT_W'(j) < k && slots[SLOT_W*j +: SLOT_W] == q_r && rank_lo) begin
        map_nxt.tmask[pos]   = 1'b1;
        map_nxt.tsel[j][pos] = 1'b1;
      end
    end
    if (operand_mask_r[q_r]) begin
      if (rank_lo && rank_r < RANK_W'(MAX_QUBITS)) map_nxt.rmask[pos] = 1'b1;
      rank_nxt = rank_r + RANK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      q_r    <= '0;
      rank_r <= '0;
      map_r  <= '0;
    end else if (wr) begin
      busy_r <= 1'b1;
      q_r    <= '0;
      rank_r <= '0;
      map_r  <= '0;
    end else if (busy_r) begin
      map_r  <= map_nxt;
      rank_r <= rank_nxt;
      q_r    <= q_r + QIDX_W'(1);
      if (q_r == '1) busy_r <= 1'b0;
    end
  end

endmodule

>>> rtl/cgme_decode.sv
// cgme_decode: second pipeline stage, classifies a query and gathers the small-matrix index
// depends on cgme_pkg and the bit map from cgme_cfg

module cgme_decode import cgme_pkg::*; #(
  parameter int MAX_TARGETS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cgme_map_t                map,
  input  logic                     v1,
  input  logic                     func1,
  input  logic [ROW_W-1:0]         row1,
  input  logic [ROW_W-1:0]         col1,
  input  logic [DATA_W-1:0]        re1,
  input  logic [DATA_W-1:0]        im1,
  input  logic                     rdy3,
  output logic                     rdy2,
  output logic                     v2,
  output logic                     func2,
  output kind_t                    kind2,
  output logic [MAX_TARGETS-1:0]   srow2,
  output logic [MAX_TARGETS-1:0]   scol2,
  output logic [2*MAX_TARGETS-1:0] addr2,
  output logic                     wok2,
  output logic [DATA_W-1:0]        re2,
  output logic [DATA_W-1:0]        im2
);

  logic                     v2_r;
  logic                     func2_r;
  kind_t                    kind2_r;
  logic [MAX_TARGETS-1:0]   srow2_r;
  logic [MAX_TARGETS-1:0]   scol2_r;
  logic [2*MAX_TARGETS-1:0] addr2_r;
  logic                     wok2_r;
  logic [DATA_W-1:0]        re2_r;
  logic [DATA_W-1:0]        im2_r;

  kind_t                    kind_nxt;
  logic [MAX_TARGETS-1:0]   srow_nxt;
  logic [MAX_TARGETS-1:0]   scol_nxt;
  logic [MAX_TARGETS-1:0]   gr;
  logic [MAX_TARGETS-1:0]   gc;
  logic                     rng;
  logic                     ctl_ok;
  logic                     blk;

  assign rdy2 = !v2_r || rdy3;

  assign rng    = (|(row1 & ~map.rmask)) || (|(col1 & ~map.rmask));
  assign ctl_ok = ((row1 & map.cmask) == map.cval) && !map.cfail;
  assign blk    = ((row1 ^ col1) & ~map.tmask) == '0;

  always_comb begin
    for (int j = 0; j < MAX_TARGETS; j++) begin
      gr[j] = |(row1 & map.tsel[j]);
      gc[j] = |(col1 & map.tsel[j]);
    end
  end

  always_comb begin
    kind_nxt = KIND_ZERO;
    srow_nxt = '0;
    scol_nxt = '0;
    if (rng) begin
      kind_nxt = KIND_RANGE;
    end else if (ctl_ok) begin
      if (blk) begin
        kind_nxt = KIND_ENTRY;
        srow_nxt = gr;
        scol_nxt = gc;
      end
    end else if (row1 == col1) begin
      kind_nxt = KIND_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      func2_r <= func1;
      kind2_r <= kind_nxt;
      srow2_r <= srow_nxt;
      scol2_r <= scol_nxt;
      wok2_r  <= ((row1 >> MAX_TARGETS) == '0) && ((col1 >> MAX_TARGETS) == '0);
      re2_r   <= re1;
      im2_r   <= im1;
      if (func1 == FUNC_LOAD) begin
        addr2_r <= {row1[MAX_TARGETS-1:0], col1[MAX_TARGETS-1:0]};
      end else begin
        addr2_r <= {srow_nxt, scol_nxt};
      end
    end
  end

  assign v2    = v2_r;
  assign func2 = func2_r;
  assign kind2 = kind2_r;
  assign srow2 = srow2_r;
  assign scol2 = scol2_r;
  assign addr2 = addr2_r;
  assign wok2  = wok2_r;
  assign re2   = re2_r;
  assign im2   = im2_r;

endmodule

>>> rtl/cgme_store.sv
// cgme_store: third pipeline stage, small-matrix entry memory written by loads and read by queries
// depends on cgme_pkg

module cgme_store import cgme_pkg::*; #(
  parameter int MAX_TARGETS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     v2,
  input  logic                     func2,
  input  kind_t                    kind2,
  input  logic [MAX_TARGETS-1:0]   srow2,
  input  logic [MAX_TARGETS-1:0]   scol2,
  input  logic [2*MAX_TARGETS-1:0] addr2,
  input  logic                     wok2,
  input  logic [DATA_W-1:0]        re2,
  input  logic [DATA_W-1:0]        im2,
  input  logic                     rdy4,
  output logic                     rdy3,
  output logic                     v3,
  output kind_t                    kind3,
  output logic [MAX_TARGETS-1:0]   srow3,
  output logic [MAX_TARGETS-1:0]   scol3,
  output logic [DATA_W-1:0]        rd_re3,
  output logic [DATA_W-1:0]        rd_im3
);

  localparam int AW    = 2 * MAX_TARGETS;
  localparam int DEPTH = 1 << AW;

  logic [DATA_W-1:0] mem_re [DEPTH];
  logic [DATA_W-1:0] mem_im [DEPTH];

  logic                   v3_r;
  kind_t                  kind3_r;
  logic [MAX_TARGETS-1:0] srow3_r;
  logic [MAX_TARGETS-1:0] scol3_r;
  logic [DATA_W-1:0]      rd_re_r;
  logic [DATA_W-1:0]      rd_im_r;
  logic                   we;

  assign rdy3 = !v3_r || rdy4;
  assign we   = rdy3 && v2 && (func2 == FUNC_LOAD) && wok2;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_re[addr2] <= re2;
      mem_im[addr2] <= im2;
    end
    if (rdy3) begin
      rd_re_r <= mem_re[addr2];
      rd_im_r <= mem_im[addr2];
    end
  end

  // loads end here, only queries move on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2 && (func2 == FUNC_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      kind3_r <= kind2;
      srow3_r <= srow2;
      scol3_r <= scol2;
    end
  end

  assign v3     = v3_r;
  assign kind3  = kind3_r;
  assign srow3  = srow3_r;
  assign scol3  = scol3_r;
  assign rd_re3 = rd_re_r;
  assign rd_im3 = rd_im_r;

endmodule

>>> rtl/controlled_gate_matrix_expand_unit.sv
// controlled_gate_matrix_expand_unit: top level, input and output registers around the pipeline
// depends on cgme_pkg, cgme_cfg, cgme_decode and cgme_store
//
//   channel   direction  handshake                  payload
//   in_       into       in_valid / in_stall        func row col entry_re entry_im
//   out_      out of     out_valid / out_stall      kind value_re value_im src_row src_col
//   cfg       into       psel penable pwrite pready paddr pwdata prdata (64-bit, 8-byte spaced)
//
// four register stages: input, decode, entry memory read, output; one transfer per cycle while in_stall is low,
// a query reaches out_valid through all four registers, loads give no result
// each register write starts a rank sweep over all 64 global qubits, one per cycle, with in_stall high
// reset clears valid bits, the config registers and the bit map; the entry memory is not cleared
// stalls ripple back only through full stages, so a bubble is filled while out_stall is high

module controlled_gate_matrix_expand_unit import cgme_pkg::*; #(
  parameter int MAX_QUBITS  = 8,
  parameter int MAX_TARGETS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [ROW_W-1:0]     in_row,
  input  logic [ROW_W-1:0]     in_col,
  input  logic [DATA_W-1:0]    in_entry_re,
  input  logic [DATA_W-1:0]    in_entry_im,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_kind,
  output logic [DATA_W-1:0]    out_value_re,
  output logic [DATA_W-1:0]    out_value_im,
  output logic [SRC_W-1:0]     out_src_row,
  output logic [SRC_W-1:0]     out_src_col,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [CFG_W-1:0]     pwdata,
  output logic [CFG_W-1:0]     prdata,
  output logic                 pready
);

  cgme_map_t map;
  logic      busy;

  logic              v1_r;
  logic              func1_r;
  logic [ROW_W-1:0]  row1_r;
  logic [ROW_W-1:0]  col1_r;
  logic [DATA_W-1:0] re1_r;
  logic [DATA_W-1:0] im1_r;
  logic              rdy1;
  logic              rdy2;
  logic              rdy3;
  logic              rdy4;
  logic              accept;

  logic                     v2;
  logic                     func2;
  kind_t                    kind2;
  logic [MAX_TARGETS-1:0]   srow2;
  logic [MAX_TARGETS-1:0]   scol2;
  logic [2*MAX_TARGETS-1:0] addr2;
  logic                     wok2;
  logic [DATA_W-1:0]        re2;
  logic [DATA_W-1:0]        im2;

  logic                   v3;
  kind_t                  kind3;
  logic [MAX_TARGETS-1:0] srow3;
  logic [MAX_TARGETS-1:0] scol3;
  logic [DATA_W-1:0]      rd_re3;
  logic [DATA_W-1:0]      rd_im3;

  logic              v4_r;
  kind_t             kind4_r;
  logic [DATA_W-1:0] vre4_r;
  logic [DATA_W-1:0] vim4_r;
  logic [SRC_W-1:0]  srow4_r;
  logic [SRC_W-1:0]  scol4_r;
  logic [DATA_W-1:0] vre_nxt;
  logic [DATA_W-1:0] vim_nxt;

  cgme_cfg #(
    .MAX_QUBITS  (MAX_QUBITS),
    .MAX_TARGETS (MAX_TARGETS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .busy    (busy),
    .map     (map)
  );

  assign rdy4     = !v4_r || !out_stall;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1 || busy;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func1_r <= in_func;
      row1_r  <= in_row;
      col1_r  <= in_col;
      re1_r   <= in_entry_re;
      im1_r   <= in_entry_im;
    end
  end

  cgme_decode #(
    .MAX_TARGETS (MAX_TARGETS)
  ) u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .map   (map),
    .v1    (v1_r),
    .func1 (func1_r),
    .row1  (row1_r),
    .col1  (col1_r),
    .re1   (re1_r),
    .im1   (im1_r),
    .rdy3  (rdy3),
    .rdy2  (rdy2),
    .v2    (v2),
    .func2 (func2),
    .kind2 (kind2),
    .srow2 (srow2),
    .scol2 (scol2),
    .addr2 (addr2),
    .wok2  (wok2),
    .re2   (re2),
    .im2   (im2)
  );

  cgme_store #(
    .MAX_TARGETS (MAX_TARGETS)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .v2     (v2),
    .func2  (func2),
    .kind2  (kind2),
    .srow2  (srow2),
    .scol2  (scol2),
    .addr2  (addr2),
    .wok2   (wok2),
    .re2    (re2),
    .im2    (im2),
    .rdy4   (rdy4),
    .rdy3   (rdy3),
    .v3     (v3),
    .kind3  (kind3),
    .srow3  (srow3),
    .scol3  (scol3),
    .rd_re3 (rd_re3),
    .rd_im3 (rd_im3)
  );

  always_comb begin
    case (kind3)
      KIND_ENTRY: begin
        vre_nxt = rd_re3;
        vim_nxt = rd_im3;
      end
      KIND_ONE: begin
        vre_nxt = ONE_BITS;
        vim_nxt = '0;
      end
      default: begin
        vre_nxt = '0;
        vim_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      kind4_r <= kind3;
      vre4_r  <= vre_nxt;
      vim4_r  <= vim_nxt;
      srow4_r <= SRC_W'(srow3);
      scol4_r <= SRC_W'(scol3);
    end
  end

  assign out_valid    = v4_r;
  assign out_kind     = kind4_r;
  assign out_value_re = vre4_r;
  assign out_value_im = vim4_r;
  assign out_src_row  = srow4_r;
  assign out_src_col  = scol4_r;

endmodule

>>> dv/cgme_element_checker.sv
// cgme_element_checker: watches the item, result and register ports of the expand unit,
// predicts each expanded element and compares it with the result that comes out
// depends on cgme_pkg

module cgme_element_checker import cgme_pkg::*; #(
  parameter int MAX_QUBITS  = 8,
  parameter int MAX_TARGETS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_func,
  input  logic [ROW_W-1:0]     in_row,
  input  logic [ROW_W-1:0]     in_col,
  input  logic [DATA_W-1:0]    in_entry_re,
  input  logic [DATA_W-1:0]    in_entry_im,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_kind,
  input  logic [DATA_W-1:0]    out_value_re,
  input  logic [DATA_W-1:0]    out_value_im,
  input  logic [SRC_W-1:0]     out_src_row,
  input  logic [SRC_W-1:0]     out_src_col,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [CFG_W-1:0]     pwdata,
  input  logic                 pready,
  output int                   pending,
  output int                   errors
);

  localparam int SMALL_DIM = 1 << MAX_TARGETS;

  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic [SRC_W-1:0]  srow;
    logic [SRC_W-1:0]  scol;
  } element_t;

  logic [CFG_W-1:0]   operand_mask;
  logic [TLIST_W-1:0] target_list;
  logic [TCNT_W-1:0]  target_count;
  logic [CFG_W-1:0]   control_mask;
  logic [CFG_W-1:0]   control_value;

  logic [DATA_W-1:0]  entry_re_mem [SMALL_DIM*SMALL_DIM];
  logic [DATA_W-1:0]  entry_im_mem [SMALL_DIM*SMALL_DIM];

  element_t element_q [$];
  int       shown = 0;

  function automatic int rank_in_set(input int q);
    return $countones(operand_mask & ((64'd1 << q) - 64'd1));
  endfunction

  function automatic element_t expand_element(input logic [ROW_W-1:0] row,
                                              input logic [ROW_W-1:0] col);
    element_t        e;
    int              n, k, q, r;
    int              rk [MAX_TARGETS];
    logic [63:0]     tmask, cmask, cval;
    logic [7:0]      addr;
    e = '{kind: KIND_ZERO, re: '0, im: '0, srow: '0, scol: '0};
    n = $countones(operand_mask);
    if (n > MAX_QUBITS) n = MAX_QUBITS;
    if ((row >> n) != 0 || (col >> n) != 0) begin
      e.kind = KIND_RANGE;
      return e;
    end
    k = (int'(target_count) > MAX_TARGETS) ? MAX_TARGETS : int'(target_count);
    tmask = '0;
    for (int j = 0; j < k; j++) begin
      q = int'(target_list[QIDX_W*j +: QIDX_W]);
      rk[j] = rank_in_set(q);
      tmask |= 64'd1 << rk[j];
    end
    cmask = '0;
    cval  = '0;
    for (q = 0; q < 64; q++) begin
      if (control_mask[q]) begin
        r = rank_in_set(q);
        cmask |= 64'd1 << r;
        cval  |= 64'(control_value[q]) << r;
      end
    end
    if ((64'(row) & cmask) == cval) begin
      if (((64'(row) ^ 64'(col)) & ~tmask) == '0) begin
        for (int j = 0; j < k; j++) begin
          e.srow[j] = 1'((64'(row) >> rk[j]) & 64'd1);
          e.scol[j] = 1'((64'(col) >> rk[j]) & 64'd1);
        end
        addr   = {e.srow, e.scol};
        e.kind = KIND_ENTRY;
        e.re   = entry_re_mem[addr];
        e.im   = entry_im_mem[addr];
      end
    end else if (row == col) begin
      e.kind = KIND_ONE;
      e.re   = ONE_BITS;
    end
    return e;
  endfunction

  always @(posedge clk) begin
    element_t want;
    int       fails;
    fails = 0;
    if (!rst_n) begin
      operand_mask  = '0;
      target_list   = '0;
      target_count  = '0;
      control_mask  = '0;
      control_value = '0;
      element_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:3])
          REG_OPERAND_MASK:  operand_mask  = pwdata;
          REG_TARGET_LIST:   target_list   = pwdata[TLIST_W-1:0];
          REG_TARGET_COUNT:  target_count  = pwdata[TCNT_W-1:0];
          REG_CONTROL_MASK:  control_mask  = pwdata;
          REG_CONTROL_VALUE: control_value = pwdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (element_q.size() == 0) begin
          fails++;
          if (shown < 10)
            $display("unexpected result: kind %0d re %h im %h", out_kind, out_value_re,
                     out_value_im);
          shown++;
        end else begin
          want = element_q.pop_front();
          if (out_kind !== want.kind || out_value_re !== want.re ||
              out_value_im !== want.im || out_src_row !== want.srow ||
              out_src_col !== want.scol) begin
            fails++;
            if (shown < 10) begin
              $display("mismatch expected: kind %0d re %h im %h src %h,%h",
                       want.kind, want.re, want.im, want.srow, want.scol);
              $display("         actual:   kind %0d re %h im %h src %h,%h",
                       out_kind, out_value_re, out_value_im, out_src_row, out_src_col);
            end
            shown++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_QUERY) begin
          element_q = {element_q, expand_element(in_row, in_col)};
        end else if (in_row < SMALL_DIM && in_col < SMALL_DIM) begin
          entry_re_mem[{in_row[MAX_TARGETS-1:0], in_col[MAX_TARGETS-1:0]}] = in_entry_re;
          entry_im_mem[{in_row[MAX_TARGETS-1:0], in_col[MAX_TARGETS-1:0]}] = in_entry_im;
        end
      end
      errors  <= errors + fails;
      pending <= element_q.size();
    end
  end

endmodule

>>> dv/tb.sv
// tb: drives loads, queries and register writes into the controlled gate matrix expand unit
// and gives the verdict; depends on cgme_pkg, the unit under rtl and cgme_element_checker

module tb;
  import cgme_pkg::*;

  localparam int QUBITS   = 8;
  localparam int TARGETS  = 4;
  localparam int IDLE_MAX = 4000;

  logic                clk;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                in_func      = FUNC_LOAD;
  logic [ROW_W-1:0]    in_row       = '0;
  logic [ROW_W-1:0]    in_col       = '0;
  logic [DATA_W-1:0]   in_entry_re  = '0;
  logic [DATA_W-1:0]   in_entry_im  = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [1:0]          out_kind;
  logic [DATA_W-1:0]   out_value_re;
  logic [DATA_W-1:0]   out_value_im;
  logic [SRC_W-1:0]    out_src_row;
  logic [SRC_W-1:0]    out_src_col;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [PADDR_W-1:0]  paddr        = '0;
  logic [CFG_W-1:0]    pwdata       = '0;
  logic [CFG_W-1:0]    prdata;
  logic                pready;

  int                  pending;
  int                  errors;
  int                  busy         = 2;
  logic                quiet        = 1'b0;
  logic                hold_req     = 1'b0;
  int                  idle_cycles  = 0;

  // row/column bit patterns that steer queries into the gate's block
  int                  dim          = 1;
  logic [7:0]          tflip        = '0;
  logic [7:0]          crank        = '0;
  logic [7:0]          cvrank       = '0;

  controlled_gate_matrix_expand_unit #(
    .MAX_QUBITS(QUBITS), .MAX_TARGETS(TARGETS)
  ) dut (.*);

  cgme_element_checker #(
    .MAX_QUBITS(QUBITS), .MAX_TARGETS(TARGETS)
  ) u_elem_chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog on cycles without any transfer
  initial begin
    while (idle_cycles < IDLE_MAX) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pwrite && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // result side: short stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && busy > 0 && $urandom_range(0, 19) < busy) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [63:0] data64();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send(input logic f, input logic [7:0] r, input logic [7:0] c,
                      input logic [63:0] re, input logic [63:0] im);
    if (!quiet && busy > 0 && $urandom_range(0, 9) < busy) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_row      <= r;
    in_col      <= c;
    in_entry_re <= re;
    in_entry_im <= im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] op, input logic [63:0] tl,
                            input logic [63:0] tc, input logic [63:0] cm,
                            input logic [63:0] cv);
    int n, k, q, r;
    quiesce();
    cfg_write(REG_OPERAND_MASK, op);
    cfg_write(REG_TARGET_LIST, tl);
    cfg_write(REG_TARGET_COUNT, tc);
    cfg_write(REG_CONTROL_MASK, cm);
    cfg_write(REG_CONTROL_VALUE, cv);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n = $countones(op);
    if (n > QUBITS) n = QUBITS;
    dim = 1 << n;
    k = (int'(tc[2:0]) > TARGETS) ? TARGETS : int'(tc[2:0]);
    tflip = '0;
    for (int j = 0; j < k; j++) begin
      q = int'(tl[6*j +: 6]);
      r = $countones(op & ((64'd1 << q) - 64'd1));
      if (r < 8) tflip[r] = 1'b1;
    end
    crank  = '0;
    cvrank = '0;
    for (q = 0; q < 64; q++) begin
      if (cm[q]) begin
        r = $countones(op & ((64'd1 << q) - 64'd1));
        if (r < 8) begin
          crank[r]  = 1'b1;
          cvrank[r] = cv[q];
        end
      end
    end
  endtask

  // mostly a qubit of the operand set, sometimes any global index
  function automatic int pick_qubit(input logic [63:0] op);
    int ops [$];
    for (int i = 0; i < 64; i++)
      if (op[i]) ops = {ops, i};
    if (ops.size() > 0 && $urandom_range(0, 3) != 0)
      return ops[$urandom_range(0, ops.size() - 1)];
    return $urandom_range(0, 63);
  endfunction

  task automatic random_config();
    logic [63:0] op, tl, tc, cm, cv;
    case ($urandom_range(0, 9))
      0:       op = '1;
      1:       op = '0;
      2:       op = (64'd1 << $urandom_range(1, 8)) - 64'd1;
      default: begin
        op = '0;
        repeat ($urandom_range(1, 10)) op |= 64'd1 << $urandom_range(0, 63);
      end
    endcase
    tl = '0;
    for (int j = 0; j < 4; j++) tl[6*j +: 6] = 6'(pick_qubit(op));
    tc = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 7)) : 64'($urandom_range(1, 4));
    cm = '0;
    repeat ($urandom_range(0, 2)) cm |= 64'd1 << pick_qubit(op);
    if ($urandom_range(0, 15) == 0) cm = {$urandom, $urandom};
    cv = cm & {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) cv |= {$urandom, $urandom};
    set_config(op, tl, tc, cm, cv);
  endtask

  task automatic rand_load();
    logic [7:0] r, c;
    if ($urandom_range(0, 19) == 0) begin
      r = 8'($urandom_range(0, 255));
      c = 8'($urandom_range(0, 255));
    end else begin
      r = 8'($urandom_range(0, 15));
      c = 8'($urandom_range(0, 15));
    end
    send(FUNC_LOAD, r, c, data64(), data64());
  endtask

  task automatic rand_query();
    int         sel;
    logic [7:0] r, c;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      r = 8'($urandom_range(0, 255));
      c = 8'($urandom_range(0, 255));
    end else begin
      r = 8'($urandom_range(0, dim - 1));
      if (sel < 7) r = (r & ~crank) | cvrank;
      if (sel < 5)
        c = r ^ (8'($urandom) & tflip);
      else if (sel < 7)
        c = r;
      else
        c = 8'($urandom_range(0, dim - 1));
    end
    send(FUNC_QUERY, r, c, data64(), data64());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole entry store so no query gathers an unwritten entry
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        send(FUNC_LOAD, 8'(r), 8'(c), {$urandom, $urandom}, {$urandom, $urandom});

    // reset settings: empty operand set, only element 0,0 in range
    send(FUNC_QUERY, 8'd0, 8'd0, '0, '0);
    send(FUNC_QUERY, 8'd1, 8'd0, '0, '0);
    send(FUNC_QUERY, 8'd255, 8'd255, '1, '1);
    send(FUNC_LOAD, 8'd16, 8'd0, '1, '1);
    send(FUNC_LOAD, 8'd0, 8'd255, '1, '1);
    send(FUNC_QUERY, 8'd0, 8'd0, '0, '0);
    send(FUNC_LOAD, 8'd0, 8'd0, '1, '1);
    send(FUNC_QUERY, 8'd0, 8'd0, '0, '0);
    send(FUNC_LOAD, 8'd15, 8'd15, '0, '0);

    // full operand set, capped size, shared target ranks, too many targets,
    // control value outside the control mask
    set_config('1, 64'd63 | (64'd5 << 18), 64'd7, 64'd1 << 7, (64'd1 << 7) | (64'd1 << 40));
    send(FUNC_QUERY, 8'd255, 8'd255, '0, '0);
    send(FUNC_QUERY, 8'd3, 8'd5, '0, '0);
    send(FUNC_QUERY, 8'd0, 8'd200, '0, '0);
    send(FUNC_QUERY, 8'd255, 8'd0, '0, '0);

    set_config(64'hFF, 64'd63 | (64'd5 << 18), 64'd4, 64'd1 << 7, 64'd1 << 7);
    send(FUNC_QUERY, 8'h80, 8'hA1, '0, '0);
    send(FUNC_QUERY, 8'h80, 8'h81, '0, '0);
    send(FUNC_QUERY, 8'hFF, 8'hDF, '0, '0);
    send(FUNC_QUERY, 8'h00, 8'h00, '0, '0);
    send(FUNC_QUERY, 8'h80, 8'h82, '0, '0);
    send(FUNC_QUERY, 8'h00, 8'h01, '0, '0);

    // sparse operand set, the first target and the control qubit absent from it
    set_config((64'd1 << 3) | (64'd1 << 10) | (64'd1 << 20) | (64'd1 << 63),
               64'd11 | (64'd63 << 6), 64'd2, 64'd1 << 5, 64'd1 << 5);
    send(FUNC_QUERY, 8'd2, 8'd6, '0, '0);
    send(FUNC_QUERY, 8'd2, 8'd10, '0, '0);
    send(FUNC_QUERY, 8'd15, 8'd3, '0, '0);
    send(FUNC_QUERY, 8'd0, 8'd0, '0, '0);
    send(FUNC_QUERY, 8'd16, 8'd0, '0, '0);
    send(FUNC_QUERY, 8'd0, 8'd16, '0, '0);

    for (int p = 0; p < 14; p++) begin
      random_config();
      quiet = (p == 13);
      busy  = quiet ? 0 : $urandom_range(0, 4);
      if (p == 2) hold_req = 1'b1;
      for (int i = 0; i < 110; i++) begin
        if (p == 4 && i == 55) quiesce();
        if ($urandom_range(0, 4) == 0)
          rand_load();
        else
          rand_query();
      end
    end

    quiesce();
    if (errors == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
rtl/cgme_pkg.sv
rtl/cgme_cfg.sv
rtl/cgme_decode.sv
rtl/cgme_store.sv
rtl/controlled_gate_matrix_expand_unit.sv
dv/cgme_element_checker.sv
dv/tb.sv
